// ===== design/crb_pkg.sv =====
// ----------------------------------------------------------------------------
// crb_pkg
// Shared types, register offsets and the state transition table of the
// command-response-buffer control area.
// ----------------------------------------------------------------------------
`default_nettype none

package crb_pkg;

    // request kinds carried in tuser
    localparam logic [1:0] OP_READ      = 2'd0;
    localparam logic [1:0] OP_WRITE     = 2'd1;
    localparam logic [1:0] OP_EXEC_DONE = 2'd2;
    localparam logic [1:0] OP_NOP       = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_INTERFACE_ID = 3'd0;
    localparam logic [2:0] CFG_CMD_ADDR     = 3'd1;
    localparam logic [2:0] CFG_CMD_SIZE     = 3'd2;
    localparam logic [2:0] CFG_RSP_ADDR     = 3'd3;
    localparam logic [2:0] CFG_RSP_SIZE     = 3'd4;
    localparam logic [2:0] CFG_LOC_COUNT    = 3'd5;
    localparam logic [2:0] CFG_IDLE_BYPASS  = 3'd6;

    // byte offsets within a locality page
    localparam logic [11:0] OFF_LOC_STATE = 12'h000;
    localparam logic [11:0] OFF_LOC_CTRL  = 12'h008;
    localparam logic [11:0] OFF_LOC_STS   = 12'h00C;
    localparam logic [11:0] OFF_ID_LO     = 12'h030;
    localparam logic [11:0] OFF_ID_HI     = 12'h034;
    localparam logic [11:0] OFF_CTRL_REQ  = 12'h040;
    localparam logic [11:0] OFF_CTRL_STS  = 12'h044;
    localparam logic [11:0] OFF_CANCEL    = 12'h048;
    localparam logic [11:0] OFF_START     = 12'h04C;
    localparam logic [11:0] OFF_INT_EN    = 12'h050;
    localparam logic [11:0] OFF_INT_STS   = 12'h054;
    localparam logic [11:0] OFF_CMD_SIZE  = 12'h058;
    localparam logic [11:0] OFF_CMD_LO    = 12'h05C;
    localparam logic [11:0] OFF_CMD_HI    = 12'h060;
    localparam logic [11:0] OFF_RSP_SIZE  = 12'h064;
    localparam logic [11:0] OFF_RSP_LO    = 12'h068;
    localparam logic [11:0] OFF_RSP_HI    = 12'h06C;
    localparam logic [11:0] OFF_BUFFER    = 12'h080;

    localparam logic [2:0] MAX_LOCALITIES = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READY,
        ST_RECEPTION,
        ST_EXECUTION,
        ST_COMPLETION
    } crb_state_t;

    // allowed next states, one bit per state
    localparam logic [7:0] NEXT_OK [8] = '{
        8'h02, 8'h07, 8'h0D, 8'h10, 8'h17, 8'h00, 8'h00, 8'h00
    };

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  loc;
        logic [11:0] offset;
        logic [31:0] wdata;
    } crb_item_t;

    typedef struct packed {
        logic [31:0] rdata;
        logic        irq;
        logic        ign;
    } crb_result_t;

    typedef struct packed {
        logic [63:0] interface_id;
        logic [63:0] cmd_addr;
        logic [12:0] cmd_size;
        logic [63:0] rsp_addr;
        logic [12:0] rsp_size;
        logic [2:0]  loc_count;
        logic        idle_bypass;
    } crb_cfg_t;

    function automatic logic crb_may_go(crb_state_t cur, crb_state_t nxt, logic bypass);
        logic ok;
        ok = NEXT_OK[cur][nxt];
        if (cur == ST_COMPLETION && (nxt == ST_READY || nxt == ST_RECEPTION) && !bypass)
        begin
            ok = 1'b0;
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

// ===== design/crb_command_interface_regs_unit.sv =====
// ----------------------------------------------------------------------------
// crb_command_interface_regs_unit
// Command-response-buffer control area, device side.
//
// Requests come in on the s_axis channel: tuser holds the operation (bus
// read, bus write, execution finished, no operation) and tdata the
// locality, byte offset and write word. Each request gives one result on
// m_axis: read word, interrupt line level and an ignored-write flag.
// Configuration (identifier, buffer addresses and sizes, locality count,
// idle bypass) is written through cfg_we / cfg_index / cfg_data.
//
// A request is accepted into the input register; from there the control
// logic updates its flags and loads the result register, which drives
// m_axis_tvalid. One request per cycle is sustained while the receiver
// takes every result. While the receiver stalls, the result holds and the
// input register still takes one more request; after that s_axis_tready
// drops until the result is taken. Reset clears the grant, returns the
// interface to idle, clears all interrupt bits and restores the
// configuration defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module crb_command_interface_regs_unit
    import crb_pkg::*;
#(
    parameter int PAGE_BYTES = 4096
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // locality, offset, write_data, pad
    input  wire logic [1:0]  s_axis_tuser,   // operation
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata    // read_data, irq, write_ignored, pad
);

    crb_item_t   item;
    logic        item_valid;
    crb_cfg_t    cfg;
    crb_result_t result;
    logic        out_free;
    logic        fire;
    logic        out_valid_reg;
    crb_result_t out_reg;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign fire     = item_valid && out_free;

    crb_in_reg u_in_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .take          (out_free),
        .item_valid    (item_valid),
        .item          (item)
    );

    crb_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    crb_ctrl #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_reg.ign, out_reg.irq, out_reg.rdata};

endmodule

`default_nettype wire

// ===== design/crb_in_reg.sv =====
// ----------------------------------------------------------------------------
// crb_in_reg
// Input register of the request stream; holds one request until the
// control stage can take it.
// ----------------------------------------------------------------------------
`default_nettype none

module crb_in_reg
    import crb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // locality, offset, write_data, pad
    input  wire logic [1:0]  s_axis_tuser,   // operation
    input  wire logic        take,
    output logic             item_valid,
    output crb_item_t        item
);

    logic      valid_reg;
    logic      valid_next;
    crb_item_t item_reg;

    // register frees up whenever the held request moves on
    assign s_axis_tready = !valid_reg || take;
    assign valid_next    = s_axis_tready ? s_axis_tvalid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg.op     <= s_axis_tuser;
            item_reg.loc    <= s_axis_tdata[2:0];
            item_reg.offset <= s_axis_tdata[14:3];
            item_reg.wdata  <= s_axis_tdata[46:15];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== design/crb_regs.sv =====
// ----------------------------------------------------------------------------
// crb_regs
// Configuration registers: identifier, buffer addresses and sizes,
// locality count and idle bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module crb_regs
    import crb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    output crb_cfg_t         cfg
);

    crb_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.interface_id <= 64'd0;
            cfg_reg.cmd_addr     <= 64'd128;
            cfg_reg.cmd_size     <= 13'd3968;
            cfg_reg.rsp_addr     <= 64'd128;
            cfg_reg.rsp_size     <= 13'd3968;
            cfg_reg.loc_count    <= 3'd5;
            cfg_reg.idle_bypass  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INTERFACE_ID: cfg_reg.interface_id <= cfg_data;
                CFG_CMD_ADDR:     cfg_reg.cmd_addr     <= cfg_data;
                CFG_CMD_SIZE:     cfg_reg.cmd_size     <= cfg_data[12:0];
                CFG_RSP_ADDR:     cfg_reg.rsp_addr     <= cfg_data;
                CFG_RSP_SIZE:     cfg_reg.rsp_size     <= cfg_data[12:0];
                CFG_LOC_COUNT:    cfg_reg.loc_count    <= cfg_data[2:0];
                CFG_IDLE_BYPASS:  cfg_reg.idle_bypass  <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== design/crb_ctrl.sv =====
// ----------------------------------------------------------------------------
// crb_ctrl
// Control area state: locality grant, interface state machine, start,
// cancel and interrupt bits, plus the read mux and ignored-write decode.
// ----------------------------------------------------------------------------
`default_nettype none

module crb_ctrl
    import crb_pkg::*;
#(
    parameter int PAGE_BYTES = 4096
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic fire,
    input  crb_item_t item,
    input  crb_cfg_t  cfg,
    output crb_result_t result
);

    localparam logic [12:0] PAGE_LIMIT = 13'(PAGE_BYTES);

    crb_state_t state_reg, state_next;
    logic       granted_reg, granted_next;
    logic [2:0] active_reg, active_next;
    logic       idle_reg, idle_next;
    logic       busy_reg, busy_next;
    logic       cancel_reg, cancel_next;
    logic [4:0] en_reg, en_next;
    logic [3:0] sts_reg, sts_next;

    logic [11:0] off;
    logic [2:0]  nloc;
    logic        loc_ok;
    logic        inpage;
    logic        owner;
    logic [31:0] reg_rdata;
    logic        ign;
    logic        do_go;
    logic        start_set;
    crb_state_t  go_tgt;

    assign off    = {item.offset[11:2], 2'b00};
    assign nloc   = (cfg.loc_count > MAX_LOCALITIES) ? MAX_LOCALITIES : cfg.loc_count;
    assign loc_ok = item.loc < nloc;
    assign inpage = {1'b0, off} < PAGE_LIMIT;
    assign owner  = loc_ok && granted_reg && (active_reg == item.loc);

    // read mux; locality and identifier words are open to every locality
    always_comb
    begin
        reg_rdata = 32'd0;
        case (off)
            OFF_LOC_STATE: reg_rdata = {24'd0, 1'b1, 2'b00, active_reg, granted_reg, 1'b0};
            OFF_LOC_STS:   reg_rdata = {31'd0, owner};
            OFF_ID_LO:     reg_rdata = cfg.interface_id[31:0];
            OFF_ID_HI:     reg_rdata = cfg.interface_id[63:32];
            default:
            begin
                if (owner)
                begin
                    case (off)
                        OFF_CTRL_STS: reg_rdata = {30'd0, idle_reg, 1'b0};
                        OFF_CANCEL:   reg_rdata = {31'd0, cancel_reg};
                        OFF_START:    reg_rdata = {31'd0, busy_reg};
                        OFF_INT_EN:   reg_rdata = {en_reg[4], 27'd0, en_reg[3:0]};
                        OFF_INT_STS:  reg_rdata = {28'd0, sts_reg};
                        OFF_CMD_SIZE: reg_rdata = {19'd0, cfg.cmd_size};
                        OFF_CMD_LO:   reg_rdata = cfg.cmd_addr[31:0];
                        OFF_CMD_HI:   reg_rdata = cfg.cmd_addr[63:32];
                        OFF_RSP_SIZE: reg_rdata = {19'd0, cfg.rsp_size};
                        OFF_RSP_LO:   reg_rdata = cfg.rsp_addr[31:0];
                        OFF_RSP_HI:   reg_rdata = cfg.rsp_addr[63:32];
                        default:      reg_rdata = 32'd0;
                    endcase
                end
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        granted_next = granted_reg;
        active_next  = active_reg;
        idle_next    = idle_reg;
        busy_next    = busy_reg;
        cancel_next  = cancel_reg;
        en_next      = en_reg;
        sts_next     = sts_reg;
        result.rdata = 32'd0;
        ign          = 1'b0;
        do_go        = 1'b0;
        start_set    = 1'b0;
        go_tgt       = ST_IDLE;

        case (item.op)
            OP_READ:
            begin
                if (loc_ok && inpage)
                begin
                    result.rdata = reg_rdata;
                end
            end
            OP_WRITE:
            begin
                if (!loc_ok)
                begin
                    ign = 1'b1;
                end
                else if (inpage)
                begin
                    if (off == OFF_LOC_CTRL)
                    begin
                        // relinquish first, then request
                        if (item.wdata[1])
                        begin
                            if (owner)
                                granted_next = 1'b0;
                            else
                                ign = 1'b1;
                        end
                        if (item.wdata[0])
                        begin
                            if (!granted_next)
                            begin
                                granted_next = 1'b1;
                                active_next  = item.loc;
                                sts_next[3]  = 1'b1;
                            end
                            else if (active_reg != item.loc)
                            begin
                                ign = 1'b1;
                            end
                        end
                    end
                    else if (off < OFF_CTRL_REQ)
                    begin
                        ign = 1'b0;
                    end
                    else if (!owner)
                    begin
                        ign = 1'b1;
                    end
                    else if (off >= OFF_BUFFER)
                    begin
                        do_go  = 1'b1;
                        go_tgt = ST_RECEPTION;
                    end
                    else
                    begin
                        case (off)
                            OFF_CTRL_REQ:
                            begin
                                case (item.wdata[1:0])
                                    2'b11: ign = 1'b1;
                                    2'b01:
                                    begin
                                        do_go  = 1'b1;
                                        go_tgt = ST_READY;
                                    end
                                    2'b10:
                                    begin
                                        do_go  = 1'b1;
                                        go_tgt = ST_IDLE;
                                    end
                                    default: ign = 1'b0;
                                endcase
                            end
                            OFF_CANCEL: cancel_next = item.wdata[0];
                            OFF_START:
                            begin
                                if (item.wdata[0])
                                begin
                                    do_go     = 1'b1;
                                    go_tgt    = ST_EXECUTION;
                                    start_set = 1'b1;
                                end
                            end
                            OFF_INT_EN:  en_next  = {item.wdata[31], item.wdata[3:0]};
                            OFF_INT_STS: sts_next = sts_reg & ~item.wdata[3:0];
                            default:     ign = 1'b0;
                        endcase
                    end
                end
            end
            OP_EXEC_DONE:
            begin
                if (state_reg == ST_EXECUTION)
                begin
                    state_next  = ST_COMPLETION;
                    idle_next   = 1'b0;
                    busy_next   = 1'b0;
                    sts_next[0] = 1'b1;
                end
            end
            default:
            begin
                ign = 1'b0;
            end
        endcase

        // state change request from control, start or buffer write
        if (do_go)
        begin
            if (crb_may_go(state_reg, go_tgt, cfg.idle_bypass))
            begin
                state_next = go_tgt;
                idle_next  = (go_tgt == ST_IDLE);
                if (go_tgt == ST_READY)
                    sts_next[1] = 1'b1;
                if (start_set)
                    busy_next = 1'b1;
            end
            else
            begin
                ign = 1'b1;
            end
        end

        result.ign = ign;
        result.irq = en_next[4] && ((sts_next & en_next[3:0]) != 4'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            granted_reg <= 1'b0;
            active_reg  <= 3'd0;
            idle_reg    <= 1'b1;
            busy_reg    <= 1'b0;
            cancel_reg  <= 1'b0;
            en_reg      <= 5'd0;
            sts_reg     <= 4'd0;
        end
        else if (fire)
        begin
            granted_reg <= granted_next;
            active_reg  <= active_next;
            idle_reg    <= idle_next;
            busy_reg    <= busy_next;
            cancel_reg  <= cancel_next;
            en_reg      <= en_next;
            sts_reg     <= sts_next;
        end
    end

    // idle status tracks the idle state
    assert property (@(posedge clk) disable iff (!rst_n)
        idle_reg == (state_reg == ST_IDLE))
        else $error("idle status out of step with interface state");

    // start stays busy only while executing
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (state_reg == ST_EXECUTION))
        else $error("start busy outside execution");

    // a rejected write leaves the interface state alone
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && result.ign) |=> (state_reg == $past(state_reg)))
        else $error("ignored write changed interface state");

    // the ready interrupt is raised on every entry into ready
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && state_reg != ST_READY && state_next == ST_READY) |=> sts_reg[1])
        else $error("cmd ready status not set on entry to ready");

endmodule

`default_nettype wire

// ===== tb/sv/tb_crb_command_interface_regs_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_crb_command_interface_regs_unit
// Self-checking bench for the command-response-buffer control area. Bus
// reads, writes and execution-finished events go in on the request stream
// with random gaps. A scoreboard keeps its own copy of the grant, the
// interface state and the interrupt bits, predicts the read word, the irq
// level and the ignored flag of every request, and checks each response
// in order. A directed opening is followed by random command cycles under
// several register settings.
// ----------------------------------------------------------------------------

module tb_crb_command_interface_regs_unit;
    import crb_pkg::*;

    localparam int PAGE_SIZE = 4096;

    // register index with nothing behind it
    localparam logic [2:0] CFG_SPARE = 3'd7;

    // CTRL_REQ request bits
    localparam logic [1:0] REQ_NONE      = 2'b00;
    localparam logic [1:0] REQ_CMD_READY = 2'b01;
    localparam logic [1:0] REQ_GO_IDLE   = 2'b10;
    localparam logic [1:0] REQ_BOTH      = 2'b11;

    // LOC_CTRL bits
    localparam logic [31:0] LOC_REQUEST    = 32'h1;
    localparam logic [31:0] LOC_RELINQUISH = 32'h2;

    localparam logic [11:0] OFF_GAP_LO = 12'h004;
    localparam logic [11:0] OFF_GAP_HI = 12'h070;

    localparam logic [11:0] MAPPED [20] = '{
        OFF_LOC_STATE, OFF_GAP_LO, OFF_LOC_CTRL, OFF_LOC_STS, OFF_ID_LO, OFF_ID_HI,
        OFF_CTRL_REQ, OFF_CTRL_STS, OFF_CANCEL, OFF_START, OFF_INT_EN, OFF_INT_STS,
        OFF_CMD_SIZE, OFF_CMD_LO, OFF_CMD_HI, OFF_RSP_SIZE, OFF_RSP_LO, OFF_RSP_HI,
        OFF_GAP_HI, OFF_BUFFER
    };

    class crb_scoreboard;
        crb_cfg_t    cfg;
        bit          granted;
        logic [2:0]  owner_loc;
        crb_state_t  state;
        bit          idle_bit;
        bit          busy_bit;
        bit          cancel_bit;
        logic [4:0]  int_en;
        logic [3:0]  int_sts;
        crb_result_t pending_results[$];
        int unsigned errors;
        int unsigned checked;

        function new();
            cfg.interface_id = 64'd0;
            cfg.cmd_addr     = 64'd128;
            cfg.cmd_size     = 13'd3968;
            cfg.rsp_addr     = 64'd128;
            cfg.rsp_size     = 13'd3968;
            cfg.loc_count    = MAX_LOCALITIES;
            cfg.idle_bypass  = 1'b0;
            granted    = 1'b0;
            owner_loc  = 3'd0;
            state      = ST_IDLE;
            idle_bit   = 1'b1;
            busy_bit   = 1'b0;
            cancel_bit = 1'b0;
            int_en     = 5'd0;
            int_sts    = 4'd0;
            errors     = 0;
            checked    = 0;
        endfunction

        function void set_config(logic [2:0] index, logic [63:0] value);
            case (index)
                CFG_INTERFACE_ID: cfg.interface_id = value;
                CFG_CMD_ADDR:     cfg.cmd_addr = value;
                CFG_CMD_SIZE:     cfg.cmd_size = value[12:0];
                CFG_RSP_ADDR:     cfg.rsp_addr = value;
                CFG_RSP_SIZE:     cfg.rsp_size = value[12:0];
                CFG_LOC_COUNT:    cfg.loc_count = value[2:0];
                CFG_IDLE_BYPASS:  cfg.idle_bypass = value[0];
                default: ;
            endcase
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        function bit legal_move(crb_state_t nxt);
            case (state)
                ST_IDLE:      return nxt == ST_READY;
                ST_READY:     return nxt inside {ST_IDLE, ST_READY, ST_RECEPTION};
                ST_RECEPTION: return nxt inside {ST_IDLE, ST_RECEPTION, ST_EXECUTION};
                ST_EXECUTION: return nxt == ST_COMPLETION;
                ST_COMPLETION:
                    return nxt inside {ST_IDLE, ST_COMPLETION} ||
                           (cfg.idle_bypass && nxt inside {ST_READY, ST_RECEPTION});
                default:      return 1'b0;
            endcase
        endfunction

        // returns 1 when the move is refused
        function bit move_to(crb_state_t nxt);
            if (!legal_move(nxt))
                return 1'b1;
            state = nxt;
            idle_bit = (nxt == ST_IDLE);
            if (nxt == ST_READY)
                int_sts[1] = 1'b1;
            return 1'b0;
        endfunction

        function logic [31:0] read_word(logic [11:0] off, bit owner);
            case (off)
                OFF_LOC_STATE: return {24'd0, 1'b1, 2'b00, owner_loc, granted, 1'b0};
                OFF_LOC_STS:   return {31'd0, owner};
                OFF_ID_LO:     return cfg.interface_id[31:0];
                OFF_ID_HI:     return cfg.interface_id[63:32];
                default: ;
            endcase
            if (off < OFF_CTRL_REQ || !owner)
                return 32'd0;
            case (off)
                OFF_CTRL_STS: return {30'd0, idle_bit, 1'b0};
                OFF_CANCEL:   return {31'd0, cancel_bit};
                OFF_START:    return {31'd0, busy_bit};
                OFF_INT_EN:   return {int_en[4], 27'd0, int_en[3:0]};
                OFF_INT_STS:  return {28'd0, int_sts};
                OFF_CMD_SIZE: return {19'd0, cfg.cmd_size};
                OFF_CMD_LO:   return cfg.cmd_addr[31:0];
                OFF_CMD_HI:   return cfg.cmd_addr[63:32];
                OFF_RSP_SIZE: return {19'd0, cfg.rsp_size};
                OFF_RSP_LO:   return cfg.rsp_addr[31:0];
                OFF_RSP_HI:   return cfg.rsp_addr[63:32];
                default:      return 32'd0;
            endcase
        endfunction

        // returns 1 when the write is flagged ignored
        function bit write_word(logic [2:0] loc, logic [11:0] off, logic [31:0] wd, bit owner);
            bit rejected;
            rejected = 1'b0;
            if (off == OFF_LOC_CTRL) begin
                // relinquish is handled before the request bit
                if (wd[1])
                begin
                    if (owner)
                        granted = 1'b0;
                    else
                        rejected = 1'b1;
                end
                if (wd[0])
                begin
                    if (!granted)
                    begin
                        granted = 1'b1;
                        owner_loc = loc;
                        int_sts[3] = 1'b1;
                    end
                    else if (owner_loc != loc)
                    begin
                        rejected = 1'b1;
                    end
                end
                return rejected;
            end
            if (off < OFF_CTRL_REQ)
                return 1'b0;
            if (!owner)
                return 1'b1;
            if (off >= OFF_BUFFER)
                return move_to(ST_RECEPTION);
            case (off)
                OFF_CTRL_REQ:
                    case (wd[1:0])
                        REQ_BOTH:      return 1'b1;
                        REQ_CMD_READY: return move_to(ST_READY);
                        REQ_GO_IDLE:   return move_to(ST_IDLE);
                        default:       return 1'b0;
                    endcase
                OFF_CANCEL:  cancel_bit = wd[0];
                OFF_START:
                    if (wd[0])
                    begin
                        if (move_to(ST_EXECUTION))
                            return 1'b1;
                        busy_bit = 1'b1;
                    end
                OFF_INT_EN:  int_en = {wd[31], wd[3:0]};
                OFF_INT_STS: int_sts = int_sts & ~wd[3:0];
                default: ;
            endcase
            return 1'b0;
        endfunction

        function void note_request(logic [1:0] op, logic [2:0] loc, logic [11:0] offset,
                                   logic [31:0] wd);
            logic [2:0]  nloc;
            logic [11:0] off;
            bit          valid;
            bit          inpage;
            bit          owner;
            crb_result_t want;
            nloc = (cfg.loc_count > MAX_LOCALITIES) ? MAX_LOCALITIES : cfg.loc_count;
            valid = loc < nloc;
            off = {offset[11:2], 2'b00};
            inpage = int'(off) < PAGE_SIZE;
            owner = valid && granted && owner_loc == loc;
            want = '0;
            case (op)
                OP_READ:
                    if (valid && inpage)
                        want.rdata = read_word(off, owner);
                OP_WRITE:
                    if (!valid)
                        want.ign = 1'b1;
                    else if (inpage)
                        want.ign = write_word(loc, off, wd, owner);
                OP_EXEC_DONE:
                    if (state == ST_EXECUTION)
                    begin
                        state = ST_COMPLETION;
                        idle_bit = 1'b0;
                        busy_bit = 1'b0;
                        int_sts[0] = 1'b1;
                    end
                default: ;
            endcase
            want.irq = int_en[4] && |(int_sts & int_en[3:0]);
            pending_results.push_back(want);
        endfunction

        function void check_result(logic [31:0] rdata, logic irq, logic ign);
            crb_result_t want;
            checked++;
            if (pending_results.size() == 0) begin
                $error("response with no request waiting: read_data %h irq %b write_ignored %b",
                       rdata, irq, ign);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (rdata !== want.rdata) begin
                $error("read_data: expected %h, actual %h", want.rdata, rdata);
                errors++;
            end
            if (irq !== want.irq) begin
                $error("irq: expected %b, actual %b", want.irq, irq);
                errors++;
            end
            if (ign !== want.ign) begin
                $error("write_ignored: expected %b, actual %b", want.ign, ign);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // locality, offset, write_data, pad
    logic [1:0]  s_axis_tuser;   // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // read_data, irq, write_ignored, pad

    crb_scoreboard sb;
    bit            burst;
    int unsigned   requests_sent;
    int unsigned   cfg_writes;

    crb_command_interface_regs_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(s_axis_tuser, s_axis_tdata[2:0], s_axis_tdata[14:3],
                                s_axis_tdata[46:15]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata[31:0], m_axis_tdata[32], m_axis_tdata[33]);
        end
    end

    function automatic int draw_gap();
        return burst ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic logic [11:0] buffer_offset();
        logic [11:0] o;
        o = 12'($urandom_range(12'h080, 12'hFFF));
        return o;
    endfunction

    function automatic logic [11:0] pick_offset();
        logic [11:0] o;
        case ($urandom_range(0, 5))
            0, 1, 2: o = MAPPED[$urandom_range(0, 19)];
            3:       o = MAPPED[$urandom_range(0, 19)] | 12'($urandom_range(0, 3));
            4:       o = buffer_offset();
            default: o = 12'($urandom_range(0, 4095));
        endcase
        return o;
    endfunction

    function automatic logic [31:0] pick_data();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 3);
            1:       return $urandom & 32'h8000_000F;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_locality();
        int n;
        n = int'((sb.cfg.loc_count > MAX_LOCALITIES) ? MAX_LOCALITIES : sb.cfg.loc_count);
        if (sb.granted && $urandom_range(0, 4) != 0)
            return sb.owner_loc;
        if (n == 0 || $urandom_range(0, 9) == 0)
            return 3'($urandom_range(0, 7));
        return 3'($urandom_range(0, n - 1));
    endfunction

    // entered and left just after a falling edge
    task automatic issue_request(logic [1:0] op, logic [2:0] loc, logic [11:0] off,
                                 logic [31:0] wd);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tuser = op;
        s_axis_tdata = {1'b0, wd, off, loc};
        s_axis_tvalid = 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        requests_sent++;
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic issue_random_request();
        logic [1:0] op;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: op = OP_READ;
            4, 5, 6, 7: op = OP_WRITE;
            8:          op = OP_EXEC_DONE;
            default:    op = OP_NOP;
        endcase
        issue_request(op, 3'($urandom_range(0, 7)), pick_offset(), pick_data());
    endtask

    task automatic inject_noise();
        if ($urandom_range(0, 6) == 0)
            issue_random_request();
    endtask

    task automatic write_config(logic [2:0] index, logic [63:0] value);
        cfg_we = 1'b1;
        cfg_index = index;
        cfg_data = value;
        sb.set_config(index, value);
        cfg_writes++;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic load_config(logic [63:0] id, logic [63:0] cmd_addr, logic [63:0] cmd_size,
                               logic [63:0] rsp_addr, logic [63:0] rsp_size,
                               logic [63:0] loc_count, logic [63:0] bypass);
        write_config(CFG_INTERFACE_ID, id);
        write_config(CFG_CMD_ADDR, cmd_addr);
        write_config(CFG_CMD_SIZE, cmd_size);
        write_config(CFG_RSP_ADDR, rsp_addr);
        write_config(CFG_RSP_SIZE, rsp_size);
        write_config(CFG_LOC_COUNT, loc_count);
        write_config(CFG_IDLE_BYPASS, bypass);
        write_config(CFG_SPARE, {$urandom, $urandom});
    endtask

    // drop the grant so a new locality count cannot strand it, then drain
    task automatic end_phase();
        if (sb.granted)
            issue_request(OP_WRITE, sb.owner_loc, OFF_LOC_CTRL, LOC_RELINQUISH);
        while (sb.outstanding() != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic run_phase(int budget, bit pressure);
        int          start_count;
        logic [2:0]  loc;
        bit          paused;
        start_count = requests_sent;
        paused = 1'b0;
        while (requests_sent - start_count < budget) begin
            burst = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(2, 6)) issue_random_request();
            end else begin
                // one command cycle: grant, cmdReady, fill, start, finish, close
                loc = pick_locality();
                issue_request(OP_WRITE, loc, OFF_LOC_CTRL,
                              ($urandom & ~LOC_RELINQUISH) | LOC_REQUEST);
                inject_noise();
                if ($urandom_range(0, 1) == 0)
                    issue_request(OP_WRITE, loc, OFF_INT_EN, pick_data());
                issue_request(OP_WRITE, loc, OFF_CTRL_REQ, ($urandom & ~32'h3) | REQ_CMD_READY);
                repeat ($urandom_range(1, 4))
                    issue_request(OP_WRITE, loc, buffer_offset(), $urandom);
                inject_noise();
                repeat ($urandom_range(0, 2)) issue_request(OP_READ, loc, pick_offset(), $urandom);
                issue_request(OP_WRITE, loc, OFF_START, $urandom | 32'h1);
                if ($urandom_range(0, 3) == 0)
                    issue_request(OP_WRITE, loc, OFF_CANCEL, $urandom);
                if ($urandom_range(0, 5) == 0)
                    issue_request(OP_WRITE, loc, OFF_CTRL_REQ, $urandom);
                repeat ($urandom_range(0, 2)) issue_request(OP_READ, loc, pick_offset(), $urandom);
                issue_request(OP_EXEC_DONE, 3'($urandom_range(0, 7)), pick_offset(), $urandom);
                issue_request(OP_READ, loc, OFF_INT_STS, $urandom);
                issue_request(OP_READ, loc, OFF_CTRL_STS, $urandom);
                issue_request(OP_WRITE, loc, OFF_INT_STS, pick_data());
                case ($urandom_range(0, 5))
                    0, 1, 2: issue_request(OP_WRITE, loc, OFF_CTRL_REQ,
                                           ($urandom & ~32'h3) | REQ_GO_IDLE);
                    3:       issue_request(OP_WRITE, loc, OFF_CTRL_REQ,
                                           ($urandom & ~32'h3) | REQ_CMD_READY);
                    4:       issue_request(OP_WRITE, loc, buffer_offset(), $urandom);
                    default: ;
                endcase
                if ($urandom_range(0, 1) == 0)
                    issue_request(OP_WRITE, loc, OFF_LOC_CTRL,
                                  ($urandom & ~LOC_REQUEST) | LOC_RELINQUISH);
                inject_noise();
            end
            burst = 1'b0;
            if (pressure && (!paused || $urandom_range(0, 3) == 0)) begin
                paused = 1'b1;
                while (sb.outstanding() != 0) @(negedge clk);
            end
        end
    endtask

    // response side: random stalls per response
    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            @(negedge clk);
        end
    end

    initial
    begin
        sb = new();
        burst = 1'b0;
        requests_sent = 0;
        cfg_writes = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_INTERFACE_ID;
        cfg_data = 64'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 48'd0;
        s_axis_tuser = OP_NOP;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed opening with reset settings
        issue_request(OP_READ, 3'd0, OFF_LOC_STATE, 32'd0);
        issue_request(OP_READ, 3'd0, OFF_CTRL_STS, 32'd0);
        issue_request(OP_WRITE, 3'd0, OFF_CTRL_REQ, {30'd0, REQ_CMD_READY});
        issue_request(OP_WRITE, 3'd7, OFF_LOC_CTRL, LOC_REQUEST);
        issue_request(OP_READ, 3'd5, OFF_ID_LO, 32'd0);
        issue_request(OP_WRITE, 3'd1, OFF_LOC_CTRL, LOC_REQUEST);
        issue_request(OP_WRITE, 3'd2, OFF_LOC_CTRL, LOC_REQUEST);
        issue_request(OP_WRITE, 3'd2, OFF_LOC_CTRL, LOC_RELINQUISH);
        issue_request(OP_READ, 3'd1, OFF_LOC_STS | 12'h3, 32'hFFFF_FFFF);
        issue_request(OP_WRITE, 3'd1, OFF_INT_EN, 32'h8000_000F);
        issue_request(OP_WRITE, 3'd1, OFF_INT_STS, 32'hFFFF_FFFF);
        issue_request(OP_WRITE, 3'd1, OFF_CTRL_REQ, {30'd0, REQ_BOTH});
        issue_request(OP_WRITE, 3'd1, OFF_CTRL_REQ, {30'd0, REQ_NONE});
        issue_request(OP_WRITE, 3'd1, OFF_START, 32'h1);
        issue_request(OP_WRITE, 3'd1, OFF_CTRL_REQ, {30'd0, REQ_CMD_READY});
        issue_request(OP_WRITE, 3'd1, 12'hFFC, 32'hFFFF_FFFF);
        issue_request(OP_WRITE, 3'd1, OFF_START, 32'hFFFF_FFFE);
        issue_request(OP_WRITE, 3'd1, OFF_START, 32'h1);
        issue_request(OP_WRITE, 3'd1, OFF_CTRL_REQ, {30'd0, REQ_GO_IDLE});
        issue_request(OP_EXEC_DONE, 3'd4, 12'hFFF, 32'h0);
        issue_request(OP_EXEC_DONE, 3'd1, OFF_LOC_STATE, 32'h0);
        issue_request(OP_WRITE, 3'd1, OFF_CTRL_REQ, {30'd0, REQ_CMD_READY});
        issue_request(OP_WRITE, 3'd1, OFF_BUFFER, 32'h1234_5678);
        issue_request(OP_NOP, 3'd7, 12'hFFF, 32'hFFFF_FFFF);
        issue_request(OP_WRITE, 3'd1, OFF_CTRL_REQ, {30'd0, REQ_GO_IDLE});
        issue_request(OP_WRITE, 3'd1, OFF_LOC_CTRL, LOC_RELINQUISH);
        end_phase();

        load_config({$urandom, $urandom}, {$urandom, $urandom}, 64'($urandom_range(0, 4096)),
                    {$urandom, $urandom}, 64'($urandom_range(0, 4096)), 64'd5, 64'd1);
        run_phase(250, 1'b0);
        end_phase();

        // all-ones values, one locality, bypass cleared through its low bit only
        load_config('1, '1, '1, '1, '1, 64'd1, 64'hFFFF_FFFF_FFFF_FFFE);
        run_phase(200, 1'b0);
        end_phase();

        write_config(CFG_LOC_COUNT, 64'd0);
        run_phase(40, 1'b0);
        end_phase();

        load_config(64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd7, 64'd1);
        run_phase(250, 1'b0);
        end_phase();

        load_config({$urandom, $urandom}, {$urandom, $urandom}, 64'($urandom_range(0, 4096)),
                    {$urandom, $urandom}, 64'($urandom_range(0, 4096)),
                    64'($urandom_range(1, 5)), 64'($urandom_range(0, 1)));
        run_phase(250, 1'b1);

        while (sb.outstanding() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        $display("run covered %0d requests and %0d responses with %0d register writes",
                 requests_sent, sb.checked, cfg_writes);
        $display("settings spanned zero to seven localities, idle bypass on and off");
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // time limit far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
